### hw/rtl/ptom_pkg.sv
// Shared types, constants and address helpers for the price-time order matcher.
// Used by ptom_book_ram and price_time_order_matcher; depends on nothing.
package ptom_pkg;

    localparam int BOOK_DEPTH = 16;
    localparam int IDX_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int ADDR_W     = $clog2(2 * BOOK_DEPTH);

    localparam logic       REQ_REST    = 1'b0;
    localparam logic       REQ_MATCH   = 1'b1;
    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic        side;
        logic [31:0] order_id;
        logic [31:0] limit_price;
        logic [31:0] order_volume;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic [31:0] trade_volume;
        logic [31:0] trade_price;
        logic [31:0] remaining_volume;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] volume;
        logic [31:0] id;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Map a queue position to a memory address: the ask side sits in the upper half.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic is_ask,
                                                     input logic [IDX_W-1:0] head,
                                                     input logic [CNT_W-1:0] pos);
        logic [CNT_W:0]    sum;
        logic [ADDR_W-1:0] base;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
        if (sum >= (CNT_W + 1)'(BOOK_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(BOOK_DEPTH);
        end
        base = is_ask ? ADDR_W'(BOOK_DEPTH) : '0;
        return base + ADDR_W'(sum[IDX_W-1:0]);
    endfunction

endpackage

### hw/rtl/ptom_book_ram.sv
// Order book storage: one synchronous memory holding both sides, with a registered read.
// Depends on ptom_pkg.
module ptom_book_ram (
    input  logic              i_clk,
    input  ptom_pkg::t_mem_req i_req,
    output ptom_pkg::t_entry   o_rd_data
);
    import ptom_pkg::*;

    t_entry r_mem [2*BOOK_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/price_time_order_matcher.sv
// Price-time order matcher: sequencer over the order book memory.
// Depends on ptom_pkg and ptom_book_ram.
//
// Usage: present a request word on i_req and raise start; it is taken at a
// rising edge where start is high and busy is low. A rest request places the
// order on its own side behind equal and better prices, or is rejected when
// that side is full; it yields one result. A match request fills against the
// opposite side, best price first, and yields one trade word per fill and a
// final done word carrying the unfilled volume (last = 1).
// Each result word is on o_res for exactly one cycle with o_valid high; the
// receiver cannot stall, and none is needed.
// Sequence: a rejected, zero-volume or first-entry rest answers the cycle after
// it is taken. Other rests walk back from the tail through ST_REST_RD and
// ST_REST_CMP, shifting each worse entry back one place, then write the order
// where the walk stops, or at the head in ST_REST_WR. A match passes through
// ST_MATCH_RD and ST_MATCH_CHK once per fill, writing back the reduced maker or
// advancing the head when the maker is used up, then gives the done word.
// Reset clears both side counts and heads; the book memory is not cleared.
module price_time_order_matcher (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ptom_pkg::t_req i_req,
    output logic           o_valid,
    output ptom_pkg::t_res o_res
);
    import ptom_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_REST_RD   = 3'd1;
    localparam logic [2:0] ST_REST_CMP  = 3'd2;
    localparam logic [2:0] ST_REST_WR   = 3'd3;
    localparam logic [2:0] ST_MATCH_RD  = 3'd4;
    localparam logic [2:0] ST_MATCH_CHK = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_head  [2];
    logic [IDX_W-1:0] n_head  [2];
    logic [CNT_W-1:0] r_count [2];
    logic [CNT_W-1:0] n_count [2];
    t_req             r_req, n_req;
    logic [31:0]      r_rem, n_rem;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    t_res             r_res, n_res;

    t_mem_req         mem_req;
    t_entry           rd_data;

    logic             sel;
    logic             better;
    logic             fail;
    logic [31:0]      used;
    t_entry           new_entry;
    t_entry           upd_entry;

    ptom_book_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Rest works on its own side, match on the opposite one; 1 selects asks.
    assign sel       = (r_req.req_type == REQ_REST) ? r_req.side : ~r_req.side;
    assign better    = sel ? (r_req.limit_price < rd_data.price)
                           : (r_req.limit_price > rd_data.price);
    assign fail      = sel ? (rd_data.price > r_req.limit_price)
                           : (rd_data.price < r_req.limit_price);
    assign used      = (rd_data.volume < r_rem) ? rd_data.volume : r_rem;
    assign new_entry = '{price: r_req.limit_price, volume: r_req.order_volume,
                         id: r_req.order_id};
    assign upd_entry = '{price: rd_data.price, volume: rd_data.volume - used,
                         id: rd_data.id};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_req     = r_req;
        n_rem     = r_rem;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_res     = '{kind: KIND_DONE, direction: r_req.side, taker_id: r_req.order_id,
                      maker_id: '0, trade_volume: '0, trade_price: '0,
                      remaining_volume: r_rem, last: 1'b1};
        mem_req   = '{we: 1'b0, waddr: '0, wdata: new_entry,
                      raddr: entry_addr(sel, r_head[sel], '0)};

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_rem = i_req.order_volume;
                    n_res.direction        = i_req.side;
                    n_res.taker_id         = i_req.order_id;
                    n_res.remaining_volume = i_req.order_volume;
                    if (i_req.req_type == REQ_REST) begin
                        if (r_count[i_req.side] == CNT_W'(BOOK_DEPTH)) begin
                            n_res.kind = KIND_REJECT;
                            n_valid    = 1'b1;
                        end else if (i_req.order_volume == '0) begin
                            n_valid = 1'b1;
                        end else if (r_count[i_req.side] == '0) begin
                            // Empty side: store at the head at once.
                            mem_req.we    = 1'b1;
                            mem_req.waddr = entry_addr(i_req.side, r_head[i_req.side], '0);
                            mem_req.wdata = '{price: i_req.limit_price,
                                              volume: i_req.order_volume,
                                              id: i_req.order_id};
                            n_count[i_req.side] = CNT_W'(1);
                            n_valid = 1'b1;
                        end else begin
                            n_idx   = r_count[i_req.side];
                            n_state = ST_REST_RD;
                        end
                    end else begin
                        n_state = ST_MATCH_RD;
                    end
                end
            end
            ST_REST_RD: begin
                mem_req.raddr = entry_addr(sel, r_head[sel], r_idx - CNT_W'(1));
                n_state = ST_REST_CMP;
            end
            ST_REST_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = entry_addr(sel, r_head[sel], r_idx);
                if (better) begin
                    // Shift the worse entry back one place and keep walking.
                    mem_req.wdata = rd_data;
                    n_idx = r_idx - CNT_W'(1);
                    n_state = (r_idx == CNT_W'(1)) ? ST_REST_WR : ST_REST_RD;
                end else begin
                    n_count[sel] = r_count[sel] + CNT_W'(1);
                    n_res.remaining_volume = r_req.order_volume;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REST_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = entry_addr(sel, r_head[sel], '0);
                n_count[sel] = r_count[sel] + CNT_W'(1);
                n_res.remaining_volume = r_req.order_volume;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_MATCH_RD: begin
                if (r_rem == '0 || r_count[sel] == '0) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MATCH_CHK;
                end
            end
            ST_MATCH_CHK: begin
                if (fail) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_rem = r_rem - used;
                    n_res.kind             = KIND_TRADE;
                    n_res.maker_id         = rd_data.id;
                    n_res.trade_volume     = used;
                    n_res.trade_price      = rd_data.price;
                    n_res.remaining_volume = r_rem - used;
                    n_res.last             = 1'b0;
                    n_valid = 1'b1;
                    if (rd_data.volume == used) begin
                        // Drop the filled maker: advance the head.
                        n_head[sel]  = (r_head[sel] == IDX_W'(BOOK_DEPTH - 1)) ? '0
                                     : r_head[sel] + IDX_W'(1);
                        n_count[sel] = r_count[sel] - CNT_W'(1);
                    end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = entry_addr(sel, r_head[sel], '0);
                        mem_req.wdata = upd_entry;
                    end
                    n_state = ST_MATCH_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '{default: '0};
            r_count <= '{default: '0};
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_req <= n_req;
        r_rem <= n_rem;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### bench/testbench.sv
// Testbench for price_time_order_matcher: directed table then random orders.
// Checks each result word against an in-bench order book model; depends on ptom_pkg.
`timescale 1ns / 1ps

module testbench;
    import ptom_pkg::*;

    localparam int N_RANDOM  = 350;
    localparam int CYC_LIMIT = 400000;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct {
        t_req req;
        bit   has_exp;
        t_res exp_res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_valid;
    t_res o_res;

    price_time_order_matcher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_res(o_res)
    );

    always #2 i_clk = ~i_clk;

    // book model: index 0 is the best price
    logic [31:0] bk_price [2][BOOK_DEPTH];
    logic [31:0] bk_vol   [2][BOOK_DEPTH];
    logic [31:0] bk_id    [2][BOOK_DEPTH];
    int          bk_cnt   [2];

    t_res pending_res[$];
    int   n_mismatch = 0;
    int   cycles = 0;
    bit   quiet = 0;

    function automatic t_res mk_res(logic [1:0] kind, logic dir, logic [31:0] taker,
                                    logic [31:0] maker, logic [31:0] vol,
                                    logic [31:0] price, logic [31:0] rem, logic last);
        t_res r;
        r.kind = kind; r.direction = dir; r.taker_id = taker; r.maker_id = maker;
        r.trade_volume = vol; r.trade_price = price; r.remaining_volume = rem;
        r.last = last;
        return r;
    endfunction

    // side index: 0 bid, 1 ask
    function automatic void predict_fills(t_req q);
        int s;
        int pos;
        logic [31:0] rem;
        logic [31:0] used;
        if (q.req_type == REQ_REST) begin
            s = q.side;
            if (bk_cnt[s] >= BOOK_DEPTH) begin
                pending_res.push_back(mk_res(KIND_REJECT, q.side, q.order_id, 0, 0, 0,
                                             q.order_volume, 1'b1));
                return;
            end
            if (q.order_volume != 0) begin
                pos = 0;
                while (pos < bk_cnt[s] && !(s ? q.limit_price < bk_price[s][pos]
                                              : q.limit_price > bk_price[s][pos]))
                    pos++;
                for (int i = bk_cnt[s]; i > pos; i--) begin
                    bk_price[s][i] = bk_price[s][i-1];
                    bk_vol[s][i]   = bk_vol[s][i-1];
                    bk_id[s][i]    = bk_id[s][i-1];
                end
                bk_price[s][pos] = q.limit_price;
                bk_vol[s][pos]   = q.order_volume;
                bk_id[s][pos]    = q.order_id;
                bk_cnt[s]++;
            end
            pending_res.push_back(mk_res(KIND_DONE, q.side, q.order_id, 0, 0, 0,
                                         q.order_volume, 1'b1));
            return;
        end
        s = (q.side == SIDE_BUY) ? 1 : 0;
        rem = q.order_volume;
        while (rem > 0 && bk_cnt[s] > 0) begin
            if (s ? bk_price[s][0] > q.limit_price : bk_price[s][0] < q.limit_price)
                break;
            used = (bk_vol[s][0] < rem) ? bk_vol[s][0] : rem;
            rem -= used;
            bk_vol[s][0] -= used;
            pending_res.push_back(mk_res(KIND_TRADE, q.side, q.order_id, bk_id[s][0],
                                         used, bk_price[s][0], rem, 1'b0));
            if (bk_vol[s][0] == 0) begin
                for (int i = 0; i < bk_cnt[s] - 1; i++) begin
                    bk_price[s][i] = bk_price[s][i+1];
                    bk_vol[s][i]   = bk_vol[s][i+1];
                    bk_id[s][i]    = bk_id[s][i+1];
                end
                bk_cnt[s]--;
            end
        end
        pending_res.push_back(mk_res(KIND_DONE, q.side, q.order_id, 0, 0, 0, rem, 1'b1));
    endfunction

    function automatic void note_mismatch(t_res e, t_res a, string what);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("MISMATCH %s: expected %p actual %p", what, e, a);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_res.size() == 0) begin
                note_mismatch('0, o_res, "unexpected word");
            end else begin
                t_res e;
                e = pending_res[0];
                pending_res.delete(0);
                if (e.kind !== o_res.kind || e.direction !== o_res.direction ||
                    e.taker_id !== o_res.taker_id || e.maker_id !== o_res.maker_id ||
                    e.trade_volume !== o_res.trade_volume ||
                    e.trade_price !== o_res.trade_price ||
                    e.remaining_volume !== o_res.remaining_volume ||
                    e.last !== o_res.last)
                    note_mismatch(e, o_res, "field");
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYC_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    t_row rows[$];

    function automatic t_req mk_req(logic rt, logic sd, logic [31:0] id,
                                    logic [31:0] px, logic [31:0] vol);
        t_req q;
        q.req_type = rt; q.side = sd; q.order_id = id; q.limit_price = px;
        q.order_volume = vol;
        return q;
    endfunction

    function automatic void add_row(t_req q, bit chk, t_res e);
        t_row r;
        r.req = q; r.has_exp = chk; r.exp_res = e;
        rows.push_back(r);
    endfunction

    // hold start until taken; random idle gap before; start stays high so the
    // next word can follow at once, and drops when idling or draining
    task automatic send_word(t_req q);
        if (!quiet) begin
            while ($urandom_range(99) < 10) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= q;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_fills(q);
    endtask

    task automatic drain_book();
        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req rand_req();
        t_req q;
        int mode;
        q.order_id = $urandom;
        q.side = 1'($urandom_range(1));
        mode = $urandom_range(99);
        q.req_type = (mode < 55) ? REQ_REST : REQ_MATCH;
        if ($urandom_range(19) == 0) q.limit_price = $urandom;
        else q.limit_price = 32'd1000 + $urandom_range(20) - 10;
        case ($urandom_range(9))
            0: q.order_volume = $urandom;
            1: q.order_volume = 32'hFFFF_FFFF;
            2: q.order_volume = 0;
            3, 4: q.order_volume = $urandom_range(300) + 1;
            default: q.order_volume = $urandom_range(40) + 1;
        endcase
        return q;
    endfunction

    initial begin
        t_req q;
        bk_cnt[0] = 0;
        bk_cnt[1] = 0;
        // directed: empty book, extremes, fill a side to reject
        q = mk_req(REQ_MATCH, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(q, 1'b1, mk_res(KIND_DONE, SIDE_BUY, 32'hFFFF_FFFF, 0, 0, 0,
                                32'hFFFF_FFFF, 1'b1));
        q = mk_req(REQ_MATCH, SIDE_SELL, 0, 0, 0);
        add_row(q, 1'b1, mk_res(KIND_DONE, SIDE_SELL, 0, 0, 0, 0, 0, 1'b1));
        q = mk_req(REQ_REST, SIDE_SELL, 7, 100, 0);
        add_row(q, 1'b1, mk_res(KIND_DONE, SIDE_SELL, 7, 0, 0, 0, 0, 1'b1));
        for (int i = 0; i < BOOK_DEPTH; i++)
            add_row(mk_req(REQ_REST, SIDE_BUY, 32'h100 + i, 32'd50 + (i % 3), 10),
                    1'b0, '0);
        q = mk_req(REQ_REST, SIDE_BUY, 32'hDEAD, 32'hFFFF_FFFF, 5);
        add_row(q, 1'b1, mk_res(KIND_REJECT, SIDE_BUY, 32'hDEAD, 0, 0, 0, 5, 1'b1));
        add_row(mk_req(REQ_MATCH, SIDE_SELL, 32'h200, 0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_req(REQ_REST, SIDE_SELL, 32'h300, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b0, '0);
        add_row(mk_req(REQ_MATCH, SIDE_BUY, 32'h301, 32'hFFFF_FFFE, 9), 1'b0, '0);
        add_row(mk_req(REQ_MATCH, SIDE_BUY, 32'h302, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                drain_book();
                send_word(rows[i].req);
                if (pending_res.size() != 1 || pending_res[0] !== rows[i].exp_res)
                    note_mismatch(rows[i].exp_res, pending_res[0], "table entry");
            end else begin
                send_word(rows[i].req);
            end
        end
        drain_book();

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 100 && n < 160);
            if (n == 250) drain_book();
            send_word(rand_req());
        end

        drain_book();
        repeat (2 * BOOK_DEPTH + 8) @(posedge i_clk);
        if (n_mismatch == 0 && pending_res.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
